[hw/rtl/ntrp_pkg.sv]
// shared types, register indexes, parse phase and outcome codes of the text record parser
package ntrp_pkg;

   // configuration port geometry
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 8;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] REG_LEAD_SKIP         = 3'd0;
   localparam logic [CsrIndexWidth-1:0] REG_EXPECTED_TNF      = 3'd1;
   localparam logic [CsrIndexWidth-1:0] REG_EXPECTED_TYPE_LEN = 3'd2;
   localparam logic [CsrIndexWidth-1:0] REG_EXPECTED_TYPE     = 3'd3;
   localparam logic [CsrIndexWidth-1:0] REG_EXPECTED_STATUS   = 3'd4;
   localparam logic [CsrIndexWidth-1:0] REG_LANG_FIRST        = 3'd5;
   localparam logic [CsrIndexWidth-1:0] REG_LANG_SECOND       = 3'd6;
   localparam logic [CsrIndexWidth-1:0] REG_MAX_RECORDS       = 3'd7;

   // parse phases
   localparam logic [3:0] PH_IDLE      = 4'd0;
   localparam logic [3:0] PH_SKIP      = 4'd1;
   localparam logic [3:0] PH_TLV_TYPE  = 4'd2;
   localparam logic [3:0] PH_TLV_LEN   = 4'd3;
   localparam logic [3:0] PH_REC_START = 4'd4;
   localparam logic [3:0] PH_TYPE_LEN  = 4'd5;
   localparam logic [3:0] PH_PAY_LEN   = 4'd6;
   localparam logic [3:0] PH_TYPE      = 4'd7;
   localparam logic [3:0] PH_STATUS    = 4'd8;
   localparam logic [3:0] PH_LANG1     = 4'd9;
   localparam logic [3:0] PH_LANG2     = 4'd10;
   localparam logic [3:0] PH_PAYLOAD   = 4'd11;
   localparam logic [3:0] PH_DONE      = 4'd12;

   // outcome codes
   localparam logic [2:0] OUT_RUNNING    = 3'd0;
   localparam logic [2:0] OUT_TERMINATOR = 3'd1;
   localparam logic [2:0] OUT_LIMIT      = 3'd2;
   localparam logic [2:0] OUT_BAD_TNF    = 3'd3;
   localparam logic [2:0] OUT_BAD_TYPE   = 3'd4;
   localparam logic [2:0] OUT_BAD_STATUS = 3'd5;
   localparam logic [2:0] OUT_BAD_LANG   = 3'd6;
   localparam logic [2:0] OUT_SHORT_LEN  = 3'd7;

   localparam logic [7:0] TERMINATOR_BYTE = 8'hFE;
   localparam logic [7:0] PREAMBLE_LEN    = 8'd3;

   typedef struct packed {
      logic [3:0] lead_skip;
      logic [2:0] expected_tnf;
      logic [7:0] expected_type_len;
      logic [7:0] expected_type;
      logic [7:0] expected_status;
      logic [7:0] lang_first;
      logic [7:0] lang_second;
      logic [7:0] max_records;
   } cfg_type;

   typedef struct packed {
      logic [3:0] parse_phase;
      logic [3:0] skip_left;
      logic [7:0] length_left;
      logic [7:0] record_counter;
      logic       tnf_ok;
      logic       type_len_ok;
   } parse_state_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       first;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic [7:0] record_number;
      logic       has_payload;
      logic       record_last;
      logic       finished;
      logic [2:0] outcome;
   } rsp_payload_type;

endpackage

[hw/rtl/ntrp_csr.sv]
// configuration registers of the text record parser
module ntrp_csr import ntrp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_LEAD_SKIP:         cfg_in.lead_skip         = csr_wdata[3:0];
            REG_EXPECTED_TNF:      cfg_in.expected_tnf      = csr_wdata[2:0];
            REG_EXPECTED_TYPE_LEN: cfg_in.expected_type_len = csr_wdata;
            REG_EXPECTED_TYPE:     cfg_in.expected_type     = csr_wdata;
            REG_EXPECTED_STATUS:   cfg_in.expected_status   = csr_wdata;
            REG_LANG_FIRST:        cfg_in.lang_first        = csr_wdata;
            REG_LANG_SECOND:       cfg_in.lang_second       = csr_wdata;
            REG_MAX_RECORDS:       cfg_in.max_records       = csr_wdata;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lead_skip         <= 4'd0;
         cfg_ff.expected_tnf      <= 3'd1;
         cfg_ff.expected_type_len <= 8'd1;
         cfg_ff.expected_type     <= 8'd84;
         cfg_ff.expected_status   <= 8'd2;
         cfg_ff.lang_first        <= 8'd101;
         cfg_ff.lang_second       <= 8'd110;
         cfg_ff.max_records       <= 8'd8;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hw/rtl/ntrp_step.sv]
// per-byte parse step: next parse state and the optional result of one byte
module ntrp_step import ntrp_pkg::*; (
   input  cfg_type         cfg,
   input  parse_state_type state_cur,
   input  req_payload_type req,
   output parse_state_type state_next,
   output logic            res_valid,
   output rsp_payload_type res
);

   parse_state_type eff;
   logic [7:0]      b;
   logic [7:0]      count_inc;
   logic            limit_hit;

   assign b         = req.in_byte;
   assign eff       = req.first ? '{parse_phase: PH_TLV_TYPE, skip_left: 4'd0,
                                    length_left: 8'd0, record_counter: 8'd0,
                                    tnf_ok: 1'b0, type_len_ok: 1'b0}
                                : state_cur;
   assign count_inc = eff.record_counter + 8'd1;
   assign limit_hit = count_inc >= cfg.max_records;

   always_comb begin
      state_next        = eff;
      res_valid         = 1'b0;
      res.payload_byte  = 8'd0;
      res.record_number = eff.record_counter;
      res.has_payload   = 1'b0;
      res.record_last   = 1'b0;
      res.finished      = 1'b0;
      res.outcome       = OUT_RUNNING;

      if (req.first && (cfg.lead_skip != 4'd0)) begin
         // first byte swallowed by the lead skip
         state_next.skip_left   = cfg.lead_skip - 4'd1;
         state_next.parse_phase = (cfg.lead_skip != 4'd1) ? PH_SKIP : PH_TLV_TYPE;
      end else begin
         unique case (eff.parse_phase)
            PH_SKIP: begin
               state_next.skip_left = eff.skip_left - 4'd1;
               if (eff.skip_left == 4'd1) begin
                  state_next.parse_phase = PH_TLV_TYPE;
               end
            end
            PH_TLV_TYPE: begin
               if (b != 8'd0) begin
                  state_next.parse_phase = PH_TLV_LEN;
               end
            end
            PH_TLV_LEN: begin
               state_next.parse_phase = PH_REC_START;
            end
            PH_REC_START: begin
               if (b == TERMINATOR_BYTE) begin
                  res_valid = 1'b1;
                  res.finished = 1'b1;
                  res.outcome = OUT_TERMINATOR;
                  state_next.parse_phase = PH_DONE;
               end else if (eff.record_counter >= cfg.max_records) begin
                  res_valid = 1'b1;
                  res.finished = 1'b1;
                  res.outcome = OUT_LIMIT;
                  state_next.parse_phase = PH_DONE;
               end else begin
                  state_next.tnf_ok      = (b[2:0] == cfg.expected_tnf);
                  state_next.parse_phase = PH_TYPE_LEN;
               end
            end
            PH_TYPE_LEN: begin
               state_next.type_len_ok = (b == cfg.expected_type_len);
               state_next.parse_phase = PH_PAY_LEN;
            end
            PH_PAY_LEN: begin
               state_next.length_left = b;
               state_next.parse_phase = PH_TYPE;
            end
            PH_TYPE: begin
               // checks in order: tnf, type length and type, short payload
               if (!eff.tnf_ok) begin
                  res_valid = 1'b1;
                  res.finished = 1'b1;
                  res.outcome = OUT_BAD_TNF;
                  state_next.parse_phase = PH_DONE;
               end else if (!eff.type_len_ok || (b != cfg.expected_type)) begin
                  res_valid = 1'b1;
                  res.finished = 1'b1;
                  res.outcome = OUT_BAD_TYPE;
                  state_next.parse_phase = PH_DONE;
               end else if (eff.length_left < PREAMBLE_LEN) begin
                  res_valid = 1'b1;
                  res.finished = 1'b1;
                  res.outcome = OUT_SHORT_LEN;
                  state_next.parse_phase = PH_DONE;
               end else begin
                  state_next.length_left = eff.length_left - PREAMBLE_LEN;
                  state_next.parse_phase = PH_STATUS;
               end
            end
            PH_STATUS: begin
               if (b != cfg.expected_status) begin
                  res_valid = 1'b1;
                  res.finished = 1'b1;
                  res.outcome = OUT_BAD_STATUS;
                  state_next.parse_phase = PH_DONE;
               end else begin
                  state_next.parse_phase = PH_LANG1;
               end
            end
            PH_LANG1: begin
               if (b != cfg.lang_first) begin
                  res_valid = 1'b1;
                  res.finished = 1'b1;
                  res.outcome = OUT_BAD_LANG;
                  state_next.parse_phase = PH_DONE;
               end else begin
                  state_next.parse_phase = PH_LANG2;
               end
            end
            PH_LANG2: begin
               if (b != cfg.lang_second) begin
                  res_valid = 1'b1;
                  res.finished = 1'b1;
                  res.outcome = OUT_BAD_LANG;
                  state_next.parse_phase = PH_DONE;
               end else if (eff.length_left == 8'd0) begin
                  // empty text completes the record here
                  res_valid = 1'b1;
                  res.record_last = 1'b1;
                  res.finished = limit_hit;
                  res.outcome = limit_hit ? OUT_LIMIT : OUT_RUNNING;
                  state_next.record_counter = count_inc;
                  state_next.parse_phase = limit_hit ? PH_DONE : PH_REC_START;
               end else begin
                  state_next.parse_phase = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               res_valid = 1'b1;
               res.payload_byte = b;
               res.has_payload = 1'b1;
               state_next.length_left = eff.length_left - 8'd1;
               if (eff.length_left == 8'd1) begin
                  res.record_last = 1'b1;
                  res.finished = limit_hit;
                  res.outcome = limit_hit ? OUT_LIMIT : OUT_RUNNING;
                  state_next.record_counter = count_inc;
                  state_next.parse_phase = limit_hit ? PH_DONE : PH_REC_START;
               end
            end
            default: begin
               // idle or done: byte ignored
               state_next = eff;
            end
         endcase
      end
   end

endmodule

[hw/rtl/ndef_text_record_parser_unit.sv]
// top level of the text record parser: parse state, result register and assertions
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   req_data   (in_byte, first)
//   rsp      out        rsp_valid/rsp_ready   rsp_data   (payload, record tag, status)
//   csr      in         csr_we                csr_index, csr_wdata
//
// one byte per cycle while req_ready is high: each transfer updates the parse state
// in the same cycle and, when the byte yields a result, loads the result register.
// the result register is the only buffer: req_ready is low only while it holds
// a result that rsp_ready does not take in that cycle.
// synchronous active-high reset puts the parse idle and the csr registers at defaults.
module ndef_text_record_parser_unit import ntrp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_payload_type          req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_payload_type          rsp_data,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   cfg_type         cfg;
   parse_state_type state_ff;
   parse_state_type state_in;
   parse_state_type step_state;
   logic            step_valid;
   rsp_payload_type step_res;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   logic            req_fire;

   ntrp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ntrp_step u_step (
      .cfg        (cfg),
      .state_cur  (state_ff),
      .req        (req_data),
      .state_next (step_state),
      .res_valid  (step_valid),
      .res        (step_res)
   );

   // input side free when the result register is empty or drains this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // parse state advances on each input transfer
   assign state_in = req_fire ? step_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.parse_phase    <= PH_IDLE;
         state_ff.skip_left      <= 4'd0;
         state_ff.length_left    <= 8'd0;
         state_ff.record_counter <= 8'd0;
         state_ff.tnf_ok         <= 1'b0;
         state_ff.type_len_ok    <= 1'b0;
      end else begin
         state_ff <= state_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (req_fire && step_valid) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && step_valid) begin
         rsp_data_ff <= step_res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // a finishing result leaves the parse in the done phase
   a_finish_done: assert property (@(posedge clock) disable iff (reset)
      (req_fire && step_valid && step_res.finished) |=> (state_ff.parse_phase == PH_DONE))
      else $error("finishing result did not end the parse");

   // finished flag and outcome code agree
   a_finish_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.finished == (rsp_data.outcome != OUT_RUNNING)))
      else $error("finished flag disagrees with outcome");

   // a result without payload carries a zero byte
   a_empty_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.has_payload) |-> (rsp_data.payload_byte == 8'd0))
      else $error("payload byte set without payload");
`endif

endmodule
